/* rtl/lgss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgss_pkg
// shared types and constants of the global search step core
// ----------------------------------------------------------------------------
package lgss_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = 9;
   localparam int DVD_W       = 65;
   localparam int DVS_W       = 60;
   localparam int STEP_W      = 7;

   typedef struct packed {
      logic [1:0]         op;
      logic signed [31:0] point;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] next_point;
      logic               stop;
      logic signed [31:0] best_point;
      logic signed [31:0] best_value;
      logic [8:0]         best_iteration;
      logic               improved;
      logic [8:0]         trial_total;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] f;
   } entry_type;

   typedef struct packed {
      logic              start;
      logic [STEP_W-1:0] steps;
   } div_req_type;

endpackage

/* rtl/lgss_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgss_ram
// trial table, one write and one registered read port
// ----------------------------------------------------------------------------
module lgss_ram (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [lgss_pkg::IDX_W-1:0] wr_addr,
   input  lgss_pkg::entry_type        wr_data,
   input  logic [lgss_pkg::IDX_W-1:0] rd_addr,
   output lgss_pkg::entry_type        rd_data
);
   import lgss_pkg::*;

   entry_type mem [TABLE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/lgss_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgss_div
// shared radix-2 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lgss_div (
   input  logic                       clock,
   input  logic                       reset,
   input  lgss_pkg::div_req_type      req,
   input  logic [lgss_pkg::DVD_W-1:0] dividend,
   input  logic [lgss_pkg::DVS_W-1:0] divisor,
   output logic                       busy,
   output logic                       done,
   output logic [lgss_pkg::DVD_W-1:0] quotient
);
   import lgss_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] left_ff, left_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [DVD_W-1:0]  quo_ff, quo_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [DVS_W:0]    rem_sh;
   logic [DVS_W:0]    diff;
   logic              ge;

   // dividend arrives top aligned, steps says how many bits to consume
   assign rem_sh = {rem_ff, dvd_ff[DVD_W-1]};
   assign diff   = rem_sh - {1'b0, dvs_ff};
   assign ge     = rem_sh >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      left_in = left_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (req.start) begin
         busy_in = 1'b1;
         left_in = req.steps;
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in  = ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
         quo_in  = {quo_ff[DVD_W-2:0], ge};
         dvd_in  = {dvd_ff[DVD_W-2:0], 1'b0};
         left_in = left_ff - STEP_W'(1);
         if (left_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff <= left_in;
      dvd_ff  <= dvd_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* rtl/lipschitz_global_search_step_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lipschitz_global_search_step_core
// one-dimensional lipschitz global minimizer over a sorted trial table
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; busy stays high
// until it ends, at the result strobe where there is one. rsp_strobe marks
// rsp_item for exactly one cycle with no way to hold it off, so capture it
// on that cycle. A left endpoint load (op 0) gives no result. A value
// transaction (op 2) with n trials in the table, inserted at interval t,
// shifts the n-t entries from t up one slot, then runs the slope pass and
// the characteristic pass over every interval (a zero-width interval gets
// no division) and forms the next point. The running time is set by the
// single shared one-bit-per-cycle divider and the single table read port.
// Configuration writes may be made only while busy is low.
module lipschitz_global_search_step_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  lgss_pkg::req_type req_item,
   output logic              rsp_strobe,
   output lgss_pkg::rsp_type rsp_item,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_index,
   input  logic [30:0]       csr_wdata
);
   import lgss_pkg::*;

   // operation and register codes
   localparam logic [1:0] OP_LEFT  = 2'd0;
   localparam logic [1:0] OP_RIGHT = 2'd1;
   localparam logic [1:0] OP_VALUE = 2'd2;
   localparam logic [1:0] CSR_RELIABILITY = 2'd0;
   localparam logic [1:0] CSR_MIN_WIDTH   = 2'd1;
   localparam logic [1:0] CSR_MAX_TRIALS  = 2'd2;

   localparam logic [47:0]      ONE_Q16  = 48'd65536;
   localparam logic [47:0]      M_MAX    = '1;
   localparam logic [DVS_W-1:0] CHAR_LIM = '1;

   // sequencer states
   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_EXEC    = 5'd1;
   localparam logic [4:0] S_OP1_CMP = 5'd2;
   localparam logic [4:0] S_SH_RD   = 5'd3;
   localparam logic [4:0] S_SH_WR   = 5'd4;
   localparam logic [4:0] S_INS     = 5'd5;
   localparam logic [4:0] S_SL_RD0  = 5'd6;
   localparam logic [4:0] S_SL_P0   = 5'd7;
   localparam logic [4:0] S_SL_DAT  = 5'd8;
   localparam logic [4:0] S_SL_DIV  = 5'd9;
   localparam logic [4:0] S_SL_NEXT = 5'd10;
   localparam logic [4:0] S_SL_FIN  = 5'd11;
   localparam logic [4:0] S_CH_RD0  = 5'd12;
   localparam logic [4:0] S_CH_P0   = 5'd13;
   localparam logic [4:0] S_CH_DAT  = 5'd14;
   localparam logic [4:0] S_CH_M1   = 5'd15;
   localparam logic [4:0] S_CH_M2   = 5'd16;
   localparam logic [4:0] S_CH_M3   = 5'd17;
   localparam logic [4:0] S_CH_DIV  = 5'd18;
   localparam logic [4:0] S_CH_SUM  = 5'd19;
   localparam logic [4:0] S_CH_CMP  = 5'd20;
   localparam logic [4:0] S_CH_NEXT = 5'd21;
   localparam logic [4:0] S_EM_RD0  = 5'd22;
   localparam logic [4:0] S_EM_RD1  = 5'd23;
   localparam logic [4:0] S_EM_DAT  = 5'd24;
   localparam logic [4:0] S_EM_DIV  = 5'd25;

   // control state
   logic [4:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [47:0]       m_ff, m_in;
   logic [IDX_W-1:0]  chosen_ff, chosen_in;
   logic signed [31:0] pending_ff, pending_in;
   logic [8:0]        iter_ff, iter_in;
   logic signed [31:0] best_x_ff, best_x_in;
   logic signed [31:0] best_f_ff, best_f_in;
   logic [8:0]        best_it_ff, best_it_in;
   logic              improved_ff, improved_in;
   logic              found_ff, found_in;
   logic [3:0]        rel_ff, rel_in;
   logic [30:0]       minw_ff, minw_in;
   logic [8:0]        maxt_ff, maxt_in;
   logic              rsp_strobe_ff, rsp_strobe_in;

   // datapath registers
   req_type           req_ff, req_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   entry_type         prev_ff, prev_in;
   entry_type         cur_ff, cur_in;
   logic signed [32:0] dx_ff, dx_in;
   logic [31:0]       dxm_ff, dxm_in;
   logic [31:0]       dzm_ff, dzm_in;
   logic              dx_neg_ff, dx_neg_in;
   logic              dz_neg_ff, dz_neg_in;
   logic signed [32:0] fsum_ff, fsum_in;
   logic signed [32:0] xsum_ff, xsum_in;
   logic [47:0]       sbest_ff, sbest_in;
   logic [63:0]       p_ff, p_in;
   logic [63:0]       lo_ff, lo_in;
   logic [DVS_W-1:0]  a_ff, a_in;
   logic [DVS_W-1:0]  b_ff, b_in;
   logic signed [63:0] c_ff, c_in;
   logic signed [63:0] top_ff, top_in;
   rsp_type           rsp_ff, rsp_in;

   // table and divider hookup
   logic              ram_we;
   logic [IDX_W-1:0]  ram_waddr;
   entry_type         ram_wdata;
   logic [IDX_W-1:0]  ram_raddr;
   entry_type         rd_data;
   div_req_type       div_req;
   logic [DVD_W-1:0]  div_dividend;
   logic [DVS_W-1:0]  div_divisor;
   logic              div_busy;
   logic              div_done;
   logic [DVD_W-1:0]  div_q;

   // shared 32x32 multiplier, result registered in p_ff
   logic [31:0]       mul_a;
   logic [31:0]       mul_b;

   // interval terms from the previous entry and the one just read
   logic signed [32:0] dx_w, dz_w, neg_dx, neg_dz, fsum_w, xsum_w;
   logic [31:0]       dxm_w, dzm_w;
   logic              last_iv;

   // wide arithmetic helpers
   logic [3:0]        r_eff;
   logic [51:0]       mr;
   logic [95:0]       prod96;
   logic [79:0]       asum;
   logic [63:0]       sum64, sgn64, fs2;
   logic signed [32:0] mid;
   logic [49:0]       corr50, nx50, mid50;
   logic signed [31:0] nx32;
   logic              stop_w;

   lgss_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (rd_data)
   );

   lgss_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_q)
   );

   assign dx_w   = $signed({rd_data.x[31], rd_data.x}) - $signed({prev_ff.x[31], prev_ff.x});
   assign dz_w   = $signed({rd_data.f[31], rd_data.f}) - $signed({prev_ff.f[31], prev_ff.f});
   assign fsum_w = $signed({rd_data.f[31], rd_data.f}) + $signed({prev_ff.f[31], prev_ff.f});
   assign xsum_w = $signed({rd_data.x[31], rd_data.x}) + $signed({prev_ff.x[31], prev_ff.x});
   assign neg_dx = -dx_w;
   assign neg_dz = -dz_w;
   assign dxm_w  = dx_w[32] ? neg_dx[31:0] : dx_w[31:0];
   assign dzm_w  = dz_w[32] ? neg_dz[31:0] : dz_w[31:0];
   assign last_iv = ({1'b0, idx_ff} + CNT_W'(1)) == count_ff;

   // slope estimate: r times the largest slope, saturated
   assign r_eff = (rel_ff == 4'd0) ? 4'd1 : rel_ff;
   assign mr    = 52'(sbest_ff) * 52'(r_eff);

   // a = m*|dx| / 2^16 from two partial products
   assign prod96 = {p_ff, 32'd0} + {32'd0, lo_ff};
   assign asum   = prod96[95:16];

   // characteristic
   assign sum64 = 64'(a_ff) + 64'(b_ff);
   assign sgn64 = dx_neg_ff ? (64'd0 - sum64) : sum64;
   assign fs2   = {{30{fsum_ff[32]}}, fsum_ff, 1'b0};

   // next point: floor of the midpoint minus the signed correction
   assign mid    = xsum_ff >>> 1;
   assign mid50  = {{17{mid[32]}}, mid};
   assign corr50 = dz_neg_ff ? (50'd0 - {2'b00, div_q[47:0]}) : {2'b00, div_q[47:0]};
   assign nx50   = mid50 - corr50;
   always_comb begin
      if (!nx50[49] && (|nx50[48:31])) begin
         nx32 = 32'sh7FFFFFFF;
      end else if (nx50[49] && !(&nx50[48:31])) begin
         nx32 = 32'sh80000000;
      end else begin
         nx32 = nx50[31:0];
      end
   end
   assign stop_w = (dx_ff < $signed({2'b00, minw_ff})) || (count_ff >= maxt_ff)
                   || (count_ff >= CNT_W'(TABLE_DEPTH));

   assign p_in = 64'(mul_a) * 64'(mul_b);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      m_in          = m_ff;
      chosen_in     = chosen_ff;
      pending_in    = pending_ff;
      iter_in       = iter_ff;
      best_x_in     = best_x_ff;
      best_f_in     = best_f_ff;
      best_it_in    = best_it_ff;
      improved_in   = improved_ff;
      found_in      = found_ff;
      rel_in        = rel_ff;
      minw_in       = minw_ff;
      maxt_in       = maxt_ff;
      rsp_strobe_in = 1'b0;
      req_in        = req_ff;
      idx_in        = idx_ff;
      prev_in       = prev_ff;
      cur_in        = cur_ff;
      dx_in         = dx_ff;
      dxm_in        = dxm_ff;
      dzm_in        = dzm_ff;
      dx_neg_in     = dx_neg_ff;
      dz_neg_in     = dz_neg_ff;
      fsum_in       = fsum_ff;
      xsum_in       = xsum_ff;
      sbest_in      = sbest_ff;
      lo_in         = lo_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      c_in          = c_ff;
      top_in        = top_ff;
      rsp_in        = rsp_ff;
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = entry_type'{x: req_ff.point, f: req_ff.value};
      ram_raddr     = '0;
      div_req       = div_req_type'{start: 1'b0, steps: '0};
      div_dividend  = '0;
      div_divisor   = '0;
      mul_a         = '0;
      mul_b         = '0;

      // configuration is taken in any cycle
      if (csr_wr_en) begin
         case (csr_index)
            CSR_RELIABILITY: rel_in  = csr_wdata[3:0];
            CSR_MIN_WIDTH:   minw_in = csr_wdata;
            CSR_MAX_TRIALS:  maxt_in = csr_wdata[8:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_item;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            case (req_ff.op)
               OP_LEFT: begin
                  ram_we    = 1'b1;
                  ram_waddr = IDX_W'(0);
                  count_in  = CNT_W'(1);
                  state_in  = S_IDLE;
               end
               OP_RIGHT: begin
                  ram_we    = 1'b1;
                  ram_waddr = IDX_W'(1);
                  count_in  = CNT_W'(2);
                  ram_raddr = IDX_W'(0);
                  state_in  = S_OP1_CMP;
               end
               OP_VALUE: begin
                  // ignored before start or with the table full
                  if (count_ff < CNT_W'(2) || count_ff >= CNT_W'(TABLE_DEPTH)) begin
                     state_in = S_IDLE;
                  end else begin
                     iter_in  = iter_ff + 9'd1;
                     idx_in   = count_ff[IDX_W-1:0] - IDX_W'(1);
                     state_in = S_SH_RD;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_OP1_CMP: begin
            // right endpoint wins ties
            if ($signed(rd_data.f) < $signed(req_ff.value)) begin
               best_x_in  = rd_data.x;
               best_f_in  = rd_data.f;
               best_it_in = 9'd1;
            end else begin
               best_x_in  = req_ff.point;
               best_f_in  = req_ff.value;
               best_it_in = 9'd2;
            end
            improved_in = 1'b1;
            iter_in     = 9'd2;
            chosen_in   = IDX_W'(1);
            state_in    = S_SL_RD0;
         end
         S_SH_RD: begin
            ram_raddr = idx_ff;
            state_in  = S_SH_WR;
         end
         S_SH_WR: begin
            // move entry up one slot to open the chosen interval
            ram_we    = 1'b1;
            ram_waddr = idx_ff + IDX_W'(1);
            ram_wdata = rd_data;
            if (idx_ff == chosen_ff) begin
               state_in = S_INS;
            end else begin
               idx_in   = idx_ff - IDX_W'(1);
               state_in = S_SH_RD;
            end
         end
         S_INS: begin
            ram_we    = 1'b1;
            ram_waddr = chosen_ff;
            ram_wdata = entry_type'{x: pending_ff, f: req_ff.value};
            count_in  = count_ff + CNT_W'(1);
            if ($signed(req_ff.value) < best_f_ff) begin
               best_x_in   = pending_ff;
               best_f_in   = req_ff.value;
               best_it_in  = iter_ff;
               improved_in = 1'b1;
            end else begin
               improved_in = 1'b0;
            end
            state_in = S_SL_RD0;
         end
         S_SL_RD0: begin
            ram_raddr = IDX_W'(0);
            idx_in    = IDX_W'(1);
            sbest_in  = '0;
            state_in  = S_SL_P0;
         end
         S_SL_P0: begin
            prev_in   = rd_data;
            ram_raddr = idx_ff;
            state_in  = S_SL_DAT;
         end
         S_SL_DAT: begin
            cur_in = rd_data;
            if (dx_w == 33'sd0) begin
               state_in = S_SL_NEXT;
            end else begin
               div_req      = div_req_type'{start: 1'b1, steps: STEP_W'(48)};
               div_dividend = {dzm_w, 33'd0};
               div_divisor  = DVS_W'(dxm_w);
               state_in     = S_SL_DIV;
            end
         end
         S_SL_DIV: begin
            if (div_done) begin
               if (div_q > DVD_W'(sbest_ff)) begin
                  sbest_in = div_q[47:0];
               end
               state_in = S_SL_NEXT;
            end
         end
         S_SL_NEXT: begin
            prev_in = cur_ff;
            if (last_iv) begin
               state_in = S_SL_FIN;
            end else begin
               idx_in    = idx_ff + IDX_W'(1);
               ram_raddr = idx_ff + IDX_W'(1);
               state_in  = S_SL_DAT;
            end
         end
         S_SL_FIN: begin
            if (sbest_ff == 48'd0) begin
               m_in = ONE_Q16;
            end else if (|mr[51:48]) begin
               m_in = M_MAX;
            end else begin
               m_in = mr[47:0];
            end
            state_in = (req_ff.op == OP_RIGHT) ? S_EM_RD0 : S_CH_RD0;
         end
         S_CH_RD0: begin
            ram_raddr = IDX_W'(0);
            idx_in    = IDX_W'(1);
            found_in  = 1'b0;
            chosen_in = IDX_W'(1);
            state_in  = S_CH_P0;
         end
         S_CH_P0: begin
            prev_in   = rd_data;
            ram_raddr = idx_ff;
            state_in  = S_CH_DAT;
         end
         S_CH_DAT: begin
            cur_in    = rd_data;
            dxm_in    = dxm_w;
            dzm_in    = dzm_w;
            dx_neg_in = dx_w[32];
            fsum_in   = fsum_w;
            if (dx_w == 33'sd0) begin
               state_in = S_CH_NEXT;
            end else begin
               mul_a    = m_ff[31:0];
               mul_b    = dxm_w;
               state_in = S_CH_M1;
            end
         end
         S_CH_M1: begin
            lo_in    = p_ff;
            mul_a    = {16'd0, m_ff[47:32]};
            mul_b    = dxm_ff;
            state_in = S_CH_M2;
         end
         S_CH_M2: begin
            a_in     = (|asum[79:60]) ? CHAR_LIM : asum[59:0];
            mul_a    = dzm_ff;
            mul_b    = dzm_ff;
            state_in = S_CH_M3;
         end
         S_CH_M3: begin
            // zero a: b saturates unless the values are equal
            if (a_ff == '0) begin
               b_in     = (dzm_ff == 32'd0) ? '0 : CHAR_LIM;
               state_in = S_CH_SUM;
            end else begin
               div_req      = div_req_type'{start: 1'b1, steps: STEP_W'(64)};
               div_dividend = {p_ff, 1'b0};
               div_divisor  = a_ff;
               state_in     = S_CH_DIV;
            end
         end
         S_CH_DIV: begin
            if (div_done) begin
               b_in     = (|div_q[64:60]) ? CHAR_LIM : div_q[59:0];
               state_in = S_CH_SUM;
            end
         end
         S_CH_SUM: begin
            c_in     = $signed(sgn64) - $signed(fs2);
            state_in = S_CH_CMP;
         end
         S_CH_CMP: begin
            // first maximum wins
            if (!found_ff || c_ff > top_ff) begin
               found_in  = 1'b1;
               top_in    = c_ff;
               chosen_in = idx_ff;
            end
            state_in = S_CH_NEXT;
         end
         S_CH_NEXT: begin
            prev_in = cur_ff;
            if (last_iv) begin
               state_in = S_EM_RD0;
            end else begin
               idx_in    = idx_ff + IDX_W'(1);
               ram_raddr = idx_ff + IDX_W'(1);
               state_in  = S_CH_DAT;
            end
         end
         S_EM_RD0: begin
            ram_raddr = chosen_ff - IDX_W'(1);
            state_in  = S_EM_RD1;
         end
         S_EM_RD1: begin
            prev_in   = rd_data;
            ram_raddr = chosen_ff;
            state_in  = S_EM_DAT;
         end
         S_EM_DAT: begin
            dx_in        = dx_w;
            dz_neg_in    = dz_w[32];
            xsum_in      = xsum_w;
            div_req      = div_req_type'{start: 1'b1, steps: STEP_W'(47)};
            div_dividend = {dzm_w, 33'd0};
            div_divisor  = DVS_W'(m_ff);
            state_in     = S_EM_DIV;
         end
         S_EM_DIV: begin
            if (div_done) begin
               pending_in            = nx32;
               rsp_in.next_point     = nx32;
               rsp_in.stop           = stop_w;
               rsp_in.best_point     = best_x_ff;
               rsp_in.best_value     = best_f_ff;
               rsp_in.best_iteration = best_it_ff;
               rsp_in.improved       = improved_ff;
               rsp_in.trial_total    = count_ff;
               rsp_strobe_in         = 1'b1;
               state_in              = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         m_ff          <= ONE_Q16;
         chosen_ff     <= IDX_W'(1);
         pending_ff    <= '0;
         iter_ff       <= '0;
         best_x_ff     <= '0;
         best_f_ff     <= '0;
         best_it_ff    <= '0;
         improved_ff   <= 1'b0;
         found_ff      <= 1'b0;
         rel_ff        <= 4'd2;
         minw_ff       <= 31'd655;
         maxt_ff       <= 9'd256;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         m_ff          <= m_in;
         chosen_ff     <= chosen_in;
         pending_ff    <= pending_in;
         iter_ff       <= iter_in;
         best_x_ff     <= best_x_in;
         best_f_ff     <= best_f_in;
         best_it_ff    <= best_it_in;
         improved_ff   <= improved_in;
         found_ff      <= found_in;
         rel_ff        <= rel_in;
         minw_ff       <= minw_in;
         maxt_ff       <= maxt_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      idx_ff    <= idx_in;
      prev_ff   <= prev_in;
      cur_ff    <= cur_in;
      dx_ff     <= dx_in;
      dxm_ff    <= dxm_in;
      dzm_ff    <= dzm_in;
      dx_neg_ff <= dx_neg_in;
      dz_neg_ff <= dz_neg_in;
      fsum_ff   <= fsum_in;
      xsum_ff   <= xsum_in;
      sbest_ff  <= sbest_in;
      p_ff      <= p_in;
      lo_ff     <= lo_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      c_ff      <= c_in;
      top_ff    <= top_in;
      rsp_ff    <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   // result only comes out as the sequencer returns to idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> state_ff == S_IDLE)
      else $error("result strobe while sequencer busy");

   // table never overfills
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("trial count above table depth");

   // divider is never restarted mid-operation
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_busy)
      else $error("divider started while busy");

   // a slope division result is consumed as it arrives, and the sequencer moves on to S_SL_NEXT
   a_sl_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SL_DIV && div_done) |=> state_ff == S_SL_NEXT)
      else $error("slope quotient not consumed");

endmodule

/* dv/lgss_tb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgss_tb_pkg
// operation codes and register indexes shared by the global search benches
// ----------------------------------------------------------------------------
package lgss_tb_pkg;

   typedef enum logic [1:0] {
      OP_LEFT  = 2'd0,
      OP_RIGHT = 2'd1,
      OP_VALUE = 2'd2,
      OP_NONE  = 2'd3
   } op_code_type;

   typedef enum logic [1:0] {
      CSR_RELIABILITY = 2'd0,
      CSR_MIN_WIDTH   = 2'd1,
      CSR_MAX_TRIALS  = 2'd2
   } csr_code_type;

endpackage

/* dv/lgss_search_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgss_search_checker
// watches the request, result and register ports of the global search core,
// keeps its own copy of the trial table and compares every result in order
// ----------------------------------------------------------------------------
module lgss_search_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  lgss_pkg::req_type req_item,
   input  logic              rsp_strobe,
   input  lgss_pkg::rsp_type rsp_item,
   input  logic              csr_wr_en,
   input  logic [1:0]        csr_index,
   input  logic [30:0]       csr_wdata,
   output int                fail_count,
   output int                pending_count
);
   import lgss_pkg::*;
   import lgss_tb_pkg::*;

   localparam longint unsigned ONE_Q16  = 64'd65536;
   localparam longint unsigned M_MAX    = 64'hFFFF_FFFF_FFFF;
   localparam longint unsigned CHAR_LIM = 64'h0FFF_FFFF_FFFF_FFFF;

   logic signed [31:0] tx [TABLE_DEPTH];
   logic signed [31:0] tf [TABLE_DEPTH];
   int unsigned        n_trials;
   longint unsigned    lip_m;
   int unsigned        pick;
   logic signed [31:0] probe_x;
   logic [8:0]         iter_no;
   logic signed [31:0] best_x;
   logic signed [31:0] best_f;
   logic [8:0]         best_it;
   logic [3:0]         rel_reg;
   logic [30:0]        width_reg;
   logic [8:0]         cap_reg;

   // expected results in order, small ring with free-running pointers
   rsp_type            exp_ring [16];
   int unsigned        exp_wr;
   int unsigned        exp_rd;

   function automatic longint unsigned umag(input longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   function automatic longint unsigned sat_lim(input logic [127:0] v);
      return (v > 128'(CHAR_LIM)) ? CHAR_LIM : v[63:0];
   endfunction

   task automatic rebuild_m();
      longint unsigned top_s, s, r, m;
      longint dx, dz;
      top_s = 0;
      for (int unsigned i = 1; i < n_trials; i++) begin
         dx = longint'(tx[i]) - longint'(tx[i-1]);
         dz = longint'(tf[i]) - longint'(tf[i-1]);
         if (dx != 0) begin
            s = (umag(dz) << 16) / umag(dx);
            if (s > top_s) top_s = s;
         end
      end
      r = (rel_reg == 0) ? 1 : rel_reg;
      m = top_s * r;
      if (m > M_MAX) m = M_MAX;
      lip_m = (top_s == 0) ? ONE_Q16 : m;
   endtask

   function automatic longint interval_rating(input int unsigned i);
      longint dx, dz, sum;
      longint unsigned a, b;
      logic [127:0] prod;
      dx = longint'(tx[i]) - longint'(tx[i-1]);
      dz = longint'(tf[i]) - longint'(tf[i-1]);
      prod = 128'(lip_m) * 128'(umag(dx));
      a = sat_lim(prod >> 16);
      if (a == 0) begin
         b = (dz == 0) ? 0 : CHAR_LIM;
      end else begin
         prod = 128'(umag(dz)) * 128'(umag(dz));
         b = sat_lim(prod / 128'(a));
      end
      sum = longint'(a + b);
      if (dx < 0) sum = -sum;
      return sum - 2 * (longint'(tf[i]) + longint'(tf[i-1]));
   endfunction

   task automatic pick_interval();
      bit     found;
      longint top_c, c;
      found = 0;
      top_c = 0;
      pick = 1;
      for (int unsigned i = 1; i < n_trials; i++) begin
         if (tx[i] != tx[i-1]) begin
            c = interval_rating(i);
            if (!found || c > top_c) begin
               found = 1;
               top_c = c;
               pick = i;
            end
         end
      end
   endtask

   // next probe point and stop rules for the chosen interval
   task automatic push_result(input logic gain);
      int unsigned t;
      longint sum, mid, corr, nx, dz, wid;
      rsp_type r;
      t = pick;
      if (t < 1 || t >= n_trials) t = 1;
      sum = longint'(tx[t-1]) + longint'(tx[t]);
      mid = sum >>> 1;
      dz = longint'(tf[t]) - longint'(tf[t-1]);
      corr = longint'((umag(dz) << 15) / lip_m);
      if (dz < 0) corr = -corr;
      nx = mid - corr;
      if (nx > 64'sd2147483647) nx = 64'sd2147483647;
      if (nx < -64'sd2147483648) nx = -64'sd2147483648;
      probe_x = nx[31:0];
      wid = longint'(tx[t]) - longint'(tx[t-1]);
      r.next_point     = probe_x;
      r.stop           = (wid < longint'(width_reg)) || (n_trials >= cap_reg) ||
                         (n_trials >= TABLE_DEPTH);
      r.best_point     = best_x;
      r.best_value     = best_f;
      r.best_iteration = best_it;
      r.improved       = gain;
      r.trial_total    = n_trials[8:0];
      exp_ring[exp_wr[3:0]] = r;
      exp_wr++;
   endtask

   task automatic predict(input req_type q);
      int unsigned t;
      logic gain;
      case (q.op)
         OP_LEFT: begin
            tx[0] = q.point;
            tf[0] = q.value;
            n_trials = 1;
         end
         OP_RIGHT: begin
            tx[1] = q.point;
            tf[1] = q.value;
            n_trials = 2;
            // right endpoint wins ties
            if (tf[0] < tf[1]) begin
               best_x = tx[0]; best_f = tf[0]; best_it = 9'd1;
            end else begin
               best_x = tx[1]; best_f = tf[1]; best_it = 9'd2;
            end
            rebuild_m();
            iter_no = 9'd2;
            pick = 1;
            push_result(1'b1);
         end
         OP_VALUE: begin
            if (n_trials >= 2 && n_trials < TABLE_DEPTH) begin
               t = pick;
               if (t < 1 || t >= n_trials) t = 1;
               iter_no = iter_no + 9'd1;
               for (int unsigned j = n_trials; j > t; j--) begin
                  tx[j] = tx[j-1];
                  tf[j] = tf[j-1];
               end
               tx[t] = probe_x;
               tf[t] = q.value;
               n_trials++;
               gain = 1'b0;
               if (q.value < best_f) begin
                  best_x = probe_x; best_f = q.value; best_it = iter_no; gain = 1'b1;
               end
               rebuild_m();
               pick_interval();
               push_result(gain);
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type exp_r;
      if (reset) begin
         n_trials  = 0;
         lip_m     = ONE_Q16;
         pick      = 1;
         probe_x   = '0;
         iter_no   = '0;
         best_x    = '0;
         best_f    = '0;
         best_it   = '0;
         rel_reg   = 4'd2;
         width_reg = 31'd655;
         cap_reg   = 9'd256;
         exp_wr    = 0;
         exp_rd    = 0;
         fail_count = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_RELIABILITY: rel_reg   = csr_wdata[3:0];
               CSR_MIN_WIDTH:   width_reg = csr_wdata;
               CSR_MAX_TRIALS:  cap_reg   = csr_wdata[8:0];
               default: ;
            endcase
         end
         if (start && !busy) predict(req_item);
         if (rsp_strobe) begin
            if (exp_wr == exp_rd) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("result with nothing expected: %p", rsp_item);
            end else begin
               exp_r = exp_ring[exp_rd[3:0]];
               exp_rd++;
               if (rsp_item.next_point !== exp_r.next_point ||
                   rsp_item.stop !== exp_r.stop ||
                   rsp_item.best_point !== exp_r.best_point ||
                   rsp_item.best_value !== exp_r.best_value ||
                   rsp_item.best_iteration !== exp_r.best_iteration ||
                   rsp_item.improved !== exp_r.improved ||
                   rsp_item.trial_total !== exp_r.trial_total) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: expected %p actual %p", exp_r, rsp_item);
               end
            end
         end
      end
      pending_count = int'(exp_wr - exp_rd);
   end

endmodule

/* dv/lipschitz_global_search_step_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lipschitz_global_search_step_core_tb
// drives endpoint and value transactions with bursty timing and register
// changes between phases; a side checker predicts and compares each result
// ----------------------------------------------------------------------------
module lipschitz_global_search_step_core_tb;
   import lgss_pkg::*;
   import lgss_tb_pkg::*;

   localparam int IDLE_LIMIT = 200000;   // far beyond one small-table step
   localparam int SETTLE     = 100;      // left endpoint load gives no result

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_item = '0;
   logic        rsp_strobe;
   rsp_type     rsp_item;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [30:0] csr_wdata = '0;
   int          fail_count;
   int          pending_count;
   int          idle_cycles = 0;
   int          burst_left = 0;
   int          sent = 0;

   always #5 clock = ~clock;

   lipschitz_global_search_step_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_strobe(rsp_strobe), .rsp_item(rsp_item),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   lgss_search_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_strobe(rsp_strobe), .rsp_item(rsp_item),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   // watchdog: cycles with no transaction and no result
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("lipschitz_global_search_step_core_tb failed");
            $finish;
         end
      end
   end

   // one transaction; returns at the rising edge that accepted it, start still high
   task automatic send_txn(input op_code_type op, input logic [31:0] pt,
                           input logic [31:0] val);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      start    <= 1'b1;
      req_item <= '{op: op, point: pt, value: val};
      forever begin
         @(negedge clock);
         if (!busy) break;
      end
      @(posedge clock);
      sent++;
   endtask

   // lower start and let every expected result arrive, plus a settle time
   task automatic drain();
      start <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_cfg(input logic [3:0] rel, input logic [30:0] wid,
                            input logic [8:0] cap);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_RELIABILITY;
      csr_wdata <= 31'(rel);
      @(posedge clock);
      csr_index <= CSR_MIN_WIDTH;
      csr_wdata <= wid;
      @(posedge clock);
      csr_index <= CSR_MAX_TRIALS;
      csr_wdata <= 31'(cap);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 3))
         0:       return $urandom;
         1:       return 32'($signed($urandom_range(0, 2000000)) - 1000000);
         default: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
      endcase
   endfunction

   initial begin
      logic [31:0] lx, rx;
      int          k;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: ignored items, extremes, zero width, reversed, flat function
      send_txn(OP_VALUE, 32'h0, 32'h0);              // before any start
      send_txn(OP_NONE, $urandom, $urandom);
      send_txn(OP_LEFT, 32'h8000_0000, 32'h7FFF_FFFF);
      send_txn(OP_VALUE, 32'h0, 32'h0);              // single trial only
      send_txn(OP_RIGHT, 32'h7FFF_FFFF, 32'h8000_0000);
      send_txn(OP_VALUE, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      send_txn(OP_VALUE, 32'h0, 32'h8000_0000);
      send_txn(OP_VALUE, 32'h0, 32'h0);
      send_txn(OP_LEFT, 32'h0, 32'd5);               // zero-width interval, tie
      send_txn(OP_RIGHT, 32'h0, 32'd5);
      send_txn(OP_VALUE, 32'h0, 32'd5);
      send_txn(OP_LEFT, 32'(100 << 16), 32'h0);      // reversed endpoints
      send_txn(OP_RIGHT, 32'(-(100 << 16)), 32'h0);
      send_txn(OP_VALUE, 32'h0, 32'd65536);
      send_txn(OP_LEFT, 32'h0, 32'h0);               // flat: slope estimate one
      send_txn(OP_RIGHT, 32'(1 << 16), 32'h0);
      send_txn(OP_VALUE, 32'h0, 32'h0);
      send_txn(OP_VALUE, 32'h0, 32'hFFFF_FFFF);
      // hold off until the pipeline is empty
      drain();
      write_cfg(4'd0, 31'd0, 9'd2);
      send_txn(OP_LEFT, 32'(-(3 << 16)), 32'd7);
      send_txn(OP_RIGHT, 32'(3 << 16), 32'd9);
      send_txn(OP_VALUE, 32'h0, 32'd1);              // past the trial limit
      send_txn(OP_VALUE, 32'h0, 32'd2);
      drain();
      write_cfg(4'd15, 31'h7FFF_FFFF, 9'd256);

      // random search sessions, with the odd broken sequence
      while (sent < 140) begin
         if ($urandom_range(0, 3) == 0) begin
            drain();
            case ($urandom_range(0, 3))
               0:       write_cfg(4'd1, 31'd0, 9'd256);
               1:       write_cfg(4'd15, 31'h7FFF_FFFF, 9'd2);
               2:       write_cfg(4'd2, 31'd655, 9'd256);
               default: write_cfg(4'($urandom_range(1, 15)), 31'($urandom & 32'h000F_FFFF),
                                  9'($urandom_range(3, 20)));
            endcase
         end
         if ($urandom_range(0, 6) == 0) begin
            send_txn(OP_NONE, $urandom, $urandom);
            send_txn(OP_LEFT, $urandom, $urandom);
            send_txn(OP_VALUE, $urandom, $urandom);  // ignored, no right endpoint
         end
         lx = $urandom;
         case ($urandom_range(0, 9))
            0:       rx = lx;
            1:       rx = $urandom;
            2:       begin rx = lx; lx = lx + $urandom_range(1, 1 << 24); end
            default: rx = lx + (($urandom_range(0, 1) == 0) ? $urandom_range(1, 1 << 24)
                                                              : $urandom);
         endcase
         send_txn(OP_LEFT, lx, rand_value());
         send_txn(OP_RIGHT, rx, rand_value());
         k = $urandom_range(1, 12);
         repeat (k) send_txn(OP_VALUE, $urandom, rand_value());
      end

      drain();
      if (fail_count == 0)
         $display("lipschitz_global_search_step_core_tb passed");
      else
         $display("lipschitz_global_search_step_core_tb failed");
      $finish;
   end

endmodule
